@@ src/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ src/htwd_pkg.sv @@
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; imported by htwd_ctrl, htwd_datapath and the top module.
package htwd_pkg;

    localparam int ALPHABET_SIZE_DEF = 256;

    localparam int IDX_W        = 9;
    localparam int SYM_W        = 8;
    localparam int CNT_W        = 32;
    localparam int OP_W         = 2;
    localparam int BYTE_W       = 8;
    localparam int BIT_CNT_W    = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_INDEX    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SYMBOLS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_DECODE  = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CUR,
        ST_NXT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic             is_leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_we;
        logic restart;
        logic begin_byte;
        logic read_walk;
        logic read_child;
        logic capture_cur;
        logic step_cur_leaf;
        logic step_nxt;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic total_hit;
        logic bits_done;
        logic cur_valid;
        logic cur_leaf;
    } status_t;

endpackage

@@ src/htwd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module htwd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/htwd_ctrl.sv @@
// Sequencing state machine of the tree-walk decoder.
// Depends on htwd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module htwd_ctrl
    import htwd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] operation,
    input  status_t         status,
    output cmd_t            cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;
    op_t    op_sel;

    assign op_sel = op_t'(operation);
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op_sel)
                        OP_LOAD:    cmd.load_we = 1'b1;
                        OP_RESTART: cmd.restart = 1'b1;
                        OP_DECODE:
                        begin
                            cmd.begin_byte = 1'b1;
                            state_next     = ST_CHECK;
                        end
                        default:    ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                // Decide what the next code bit needs, or finish the word.
                if (status.bits_done || status.total_hit)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!status.cur_valid)
                begin
                    cmd.read_walk = 1'b1;
                    state_next    = ST_CUR;
                end
                else if (status.cur_leaf)
                begin
                    cmd.step_cur_leaf = 1'b1;
                end
                else
                begin
                    cmd.read_child = 1'b1;
                    state_next     = ST_NXT;
                end
            end
            ST_CUR:
            begin
                cmd.capture_cur = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_NXT:
            begin
                cmd.step_nxt = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NXT(a_child_read_lands, clk, rst_n, cmd.read_child, state_reg == ST_NXT && cmd.step_nxt)
    `ASSERT_NXT(a_flush_frees, clk, rst_n, state_reg == ST_FLUSH, !busy)

endmodule

@@ src/htwd_datapath.sv @@
// Datapath of the tree-walk decoder: node table, walk and count registers,
// pending-symbol stage and result registers. Depends on htwd_pkg, htwd_ram.
`include "assert_macros.svh"

module htwd_datapath
    import htwd_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IDX_W-1:0]      node_index,
    input  logic                  node_is_leaf,
    input  logic [SYM_W-1:0]      node_symbol,
    input  logic [IDX_W-1:0]      left_child,
    input  logic [IDX_W-1:0]      right_child,
    input  logic [BYTE_W-1:0]     code_byte,
    output logic                  result_valid,
    output logic [SYM_W-1:0]      symbol,
    output logic                  last_of_run,
    output logic                  stream_done
);

    localparam int DEPTH = 2 * ALPHABET_SIZE - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

    // Control registers.
    logic [IDX_W-1:0]     root_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [IDX_W-1:0]     walk_reg;
    logic [CNT_W-1:0]     emitted_reg;
    logic [BIT_CNT_W-1:0] bitcnt_reg;
    logic                 cur_valid_reg;
    logic                 pend_valid_reg;
    logic                 out_valid_reg;

    // Payload registers.
    logic [BYTE_W-1:0]    byte_reg;
    node_t                cur_node_reg;
    logic [IDX_W-1:0]     next_idx_reg;
    logic                 rd_oob_reg;
    logic [SYM_W-1:0]     pend_sym_reg;
    logic                 pend_done_reg;
    logic [SYM_W-1:0]     out_sym_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;

    logic [NODE_W-1:0]    ram_rdata;
    logic                 rd_en;
    logic [IDX_W-1:0]     child_idx;
    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_oob;
    node_t                node_q;
    node_t                wr_node;
    logic                 wr_en;
    logic                 emit;
    logic [SYM_W-1:0]     emit_sym;
    logic                 step;
    logic                 put_out;
    logic [CNT_W-1:0]     emitted_inc;

    always_comb
    begin
        rd_en     = cmd.read_walk | cmd.read_child;
        child_idx = byte_reg[BYTE_W-1] ? cur_node_reg.right : cur_node_reg.left;
        rd_idx    = cmd.read_walk ? walk_reg : child_idx;
        rd_oob    = (rd_idx >= DEPTH_IDX);
        // An index past the table reads as an inner node with both children zero.
        node_q    = rd_oob_reg ? node_t'('0) : node_t'(ram_rdata);

        wr_en           = cmd.load_we & (node_index < DEPTH_IDX);
        wr_node.is_leaf = node_is_leaf;
        wr_node.sym     = node_symbol;
        wr_node.left    = left_child;
        wr_node.right   = right_child;

        emit        = cmd.step_cur_leaf | (cmd.step_nxt & node_q.is_leaf);
        emit_sym    = cmd.step_cur_leaf ? cur_node_reg.sym : node_q.sym;
        step        = cmd.step_cur_leaf | cmd.step_nxt;
        put_out     = (emit | cmd.flush) & pend_valid_reg;
        emitted_inc = emitted_reg + CNT_W'(1);
    end

    htwd_ram #(
        .WIDTH  (NODE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (node_index[AW-1:0]),
        .wdata (wr_node),
        .re    (rd_en),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg       <= '0;
            total_reg      <= '0;
            walk_reg       <= '0;
            emitted_reg    <= '0;
            bitcnt_reg     <= '0;
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_ROOT_INDEX)
            begin
                root_reg <= cfg_data[IDX_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_TOTAL_SYMBOLS)
            begin
                total_reg <= cfg_data[CNT_W-1:0];
            end

            if (cmd.restart)
            begin
                walk_reg    <= root_reg;
                emitted_reg <= '0;
            end
            if (cmd.begin_byte)
            begin
                bitcnt_reg    <= '0;
                cur_valid_reg <= 1'b0;
            end
            if (cmd.capture_cur)
            begin
                cur_valid_reg <= 1'b1;
            end
            if (cmd.step_cur_leaf)
            begin
                walk_reg      <= root_reg;
                cur_valid_reg <= 1'b0;
            end
            if (cmd.step_nxt)
            begin
                if (node_q.is_leaf)
                begin
                    walk_reg      <= root_reg;
                    cur_valid_reg <= 1'b0;
                end
                else
                begin
                    walk_reg      <= next_idx_reg;
                    cur_valid_reg <= 1'b1;
                end
            end
            if (step)
            begin
                bitcnt_reg <= bitcnt_reg + BIT_CNT_W'(1);
            end
            if (emit)
            begin
                emitted_reg <= emitted_inc;
            end

            if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= put_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_byte)
        begin
            byte_reg <= code_byte;
        end
        else if (step)
        begin
            byte_reg <= {byte_reg[BYTE_W-2:0], 1'b0};
        end
        if (cmd.capture_cur || (cmd.step_nxt && !node_q.is_leaf))
        begin
            cur_node_reg <= node_q;
        end
        if (cmd.read_child)
        begin
            next_idx_reg <= child_idx;
        end
        if (rd_en)
        begin
            rd_oob_reg <= rd_oob;
        end
        if (emit)
        begin
            pend_sym_reg  <= emit_sym;
            pend_done_reg <= (emitted_inc == total_reg);
        end
        if (put_out)
        begin
            out_sym_reg  <= pend_sym_reg;
            out_last_reg <= cmd.flush;
            out_done_reg <= pend_done_reg;
        end
    end

    assign status.total_hit = (emitted_reg >= total_reg);
    assign status.bits_done = (bitcnt_reg == BITS_PER_BYTE);
    assign status.cur_valid = cur_valid_reg;
    assign status.cur_leaf  = cur_node_reg.is_leaf;

    assign result_valid = out_valid_reg;
    assign symbol       = out_sym_reg;
    assign last_of_run  = out_last_reg;
    assign stream_done  = out_done_reg;

    `ASSERT_IMP(a_out_from_pending, clk, rst_n, out_valid_reg, $past(pend_valid_reg))
    `ASSERT_IMP(a_done_closes_word, clk, rst_n, out_valid_reg && out_done_reg, out_last_reg)
    `ASSERT_IMP(a_child_of_inner, clk, rst_n, cmd.read_child, cur_valid_reg && !cur_node_reg.is_leaf)

endmodule

@@ src/huffman_tree_walk_decoder.sv @@
// Huffman tree-walk decoder: a node table is loaded one node per word, then
// each code byte is walked most significant bit first and every leaf that the
// walk reaches is sent out as one decoded symbol. The symbol output cannot be
// stalled: each result appears on symbol, last_of_run and stream_done for
// exactly one cycle with result_valid high, and the receiver must take it
// then. A load or restart word leaves busy low. A code byte raises busy
// while it is being walked: every bit needs a dependent read of the node
// table, whose read data is registered, so a bit that continues from an
// inner node reads the child and then steps, while the first bit of a
// byte and a bit that starts again at the root after a symbol must first
// fetch and capture the starting node, and emit its symbol at once when
// that node is itself a leaf. A flush state closes the byte, and the last
// symbol of the byte is sent out in the same cycle that busy
// drops. Because last_of_run can only be known once the rest of the byte has
// been walked, each symbol is held back one step and sent when the next one
// is found or when the byte ends. The node table has no reset: a walk that
// reaches a node never loaded gives undefined symbols. A walk to the index
// just past the table reads an inner node with both children at index zero.
// Writing root_index does not move the walk; a restart word or a completed
// symbol does. After total_symbols symbols, code bytes produce nothing until
// the next restart, and a total of zero means nothing is ever produced.
// Configuration may be written only while busy is low and no result is due.
// Depends on htwd_pkg, htwd_ctrl and htwd_datapath.

module huffman_tree_walk_decoder
    import htwd_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // Command channel: a word is taken when start is high and busy is low.
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       operation,
    input  logic [IDX_W-1:0]      node_index,
    input  logic                  node_is_leaf,
    input  logic [SYM_W-1:0]      node_symbol,
    input  logic [IDX_W-1:0]      left_child,
    input  logic [IDX_W-1:0]      right_child,
    input  logic [BYTE_W-1:0]     code_byte,

    // Configuration write port: index 0 is root_index, index 1 total_symbols.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Result channel: one word per cycle in which result_valid is high.
    output logic                  result_valid,
    output logic [SYM_W-1:0]      symbol,
    output logic                  last_of_run,
    output logic                  stream_done
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences each code byte bit by bit; the datapath holds
    // the table, the walk position, the symbol count and the result stage.
    htwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    htwd_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .node_index   (node_index),
        .node_is_leaf (node_is_leaf),
        .node_symbol  (node_symbol),
        .left_child   (left_child),
        .right_child  (right_child),
        .code_byte    (code_byte),
        .result_valid (result_valid),
        .symbol       (symbol),
        .last_of_run  (last_of_run),
        .stream_done  (stream_done)
    );

endmodule
